// ===== hdl/inverse_affine_pixel_warp_unit_defines.svh =====
// assertion macros shared by the warp unit modules
// no dependencies; included by files that carry concurrent checks
`ifndef INVERSE_AFFINE_PIXEL_WARP_UNIT_DEFINES_SVH
`define INVERSE_AFFINE_PIXEL_WARP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IAPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iapw check failed");

// next-cycle implication, disabled while reset is asserted
`define IAPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iapw check failed");

`endif

// ===== hdl/iapw_pkg.sv =====
// shared types and constants of the inverse affine pixel warp unit
// no dependencies; used by controller, datapath and top level
package iapw_pkg;

    localparam int POS_W   = 9;
    localparam int PIX_W   = 24;
    localparam int COEF_W  = 32;
    localparam int DIM_W   = 10;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W  = COEF_W + POS_W + 1;
    localparam int ACC_W   = PROD_W + 2;

    // request command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WARP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 4'd7;

    // multiply-accumulate term select
    localparam logic [1:0] MAC_XX = 2'd0;
    localparam logic [1:0] MAC_XY = 2'd1;
    localparam logic [1:0] MAC_YX = 2'd2;
    localparam logic [1:0] MAC_YY = 2'd3;

    typedef struct packed {
        logic       load_we;
        logic       capture;
        logic       mac_en;
        logic       mac_init;
        logic [1:0] mac_sel;
        logic       latch_sx;
        logic       latch_sy;
        logic       mem_rd;
        logic       out_load;
    } t_dp_cmd;

endpackage

// ===== hdl/inverse_affine_pixel_warp_unit.sv =====
// top level of the inverse affine pixel warp unit, nearest neighbour
// depends on iapw_pkg, iapw_ctrl, iapw_dp and inverse_affine_pixel_warp_unit_defines.svh
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_command i_pos_x i_pos_y i_pixel_in
// output    out        o_out_valid / i_out_stall  o_pixel_out o_inside_res
// config    in         i_cfg_we (no wait)         i_cfg_index i_cfg_data
//
// a load request is written into the frame store at acceptance, one per cycle when idle
// a warp request passes from acceptance to the result register through the single
// shared multiply-accumulate (four terms) and the frame store read port
// while a warp is in flight the input is stalled; a held result waits in the
// output register and loads keep flowing behind it
// synchronous active-low reset restores the identity transform and a 512x512 frame;
// the frame store is not cleared and holds nothing defined until loaded
`include "inverse_affine_pixel_warp_unit_defines.svh"

module inverse_affine_pixel_warp_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic [iapw_pkg::POS_W-1:0]        i_pos_x,
    input  logic [iapw_pkg::POS_W-1:0]        i_pos_y,
    input  logic [iapw_pkg::PIX_W-1:0]        i_pixel_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [iapw_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_inside_res,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [iapw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iapw_pkg::COEF_W-1:0]       i_cfg_data
);

    // command bundle from sequencer to datapath
    iapw_pkg::t_dp_cmd w_cmd;

    // sequencer: accepts requests, steps the warp, owns result valid
    iapw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // datapath: coefficients, mac, truncation, bounds, frame store, result
    iapw_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_in   (i_pixel_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res)
    );

    // a source outside the frame always returns black
    `IAPW_ASSERT_IMP(a_outside_is_black, i_clk, i_rst_n, o_out_valid && !o_inside_res, o_pixel_out == '0)

endmodule

// ===== hdl/iapw_ctrl.sv =====
// sequencing state machine of the warp unit: handshakes and datapath commands
// depends on iapw_pkg and inverse_affine_pixel_warp_unit_defines.svh
`include "inverse_affine_pixel_warp_unit_defines.svh"

module iapw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_command,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output iapw_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MX0  = 3'd1;
    localparam logic [2:0] S_MX1  = 3'd2;
    localparam logic [2:0] S_MY0  = 3'd3;
    localparam logic [2:0] S_MY1  = 3'd4;
    localparam logic [2:0] S_TRY  = 3'd5;
    localparam logic [2:0] S_RDM  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == iapw_pkg::CMD_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_MX0;
                    end
                end
            end
            S_MX0: begin
                o_cmd.mac_en   = 1'b1;
                o_cmd.mac_init = 1'b1;
                o_cmd.mac_sel  = iapw_pkg::MAC_XX;
                n_state        = S_MX1;
            end
            S_MX1: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = iapw_pkg::MAC_XY;
                n_state       = S_MY0;
            end
            S_MY0: begin
                o_cmd.mac_en   = 1'b1;
                o_cmd.mac_init = 1'b1;
                o_cmd.mac_sel  = iapw_pkg::MAC_YX;
                o_cmd.latch_sx = 1'b1;
                n_state        = S_MY1;
            end
            S_MY1: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_sel = iapw_pkg::MAC_YY;
                n_state       = S_TRY;
            end
            S_TRY: begin
                o_cmd.latch_sy = 1'b1;
                n_state        = S_RDM;
            end
            S_RDM: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // a load is written at acceptance and never leaves idle
    `IAPW_ASSERT_NXT(a_load_stays_idle, i_clk, i_rst_n, w_accept && (i_command == iapw_pkg::CMD_LOAD), r_state == S_IDLE)
    // a result appears only after the done step
    `IAPW_ASSERT_IMP(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    // a finished warp waits while the held result is stalled
    `IAPW_ASSERT_NXT(a_done_waits, i_clk, i_rst_n, (r_state == S_DONE) && r_out_valid && i_out_stall, r_state == S_DONE)

endmodule

// ===== hdl/iapw_dp.sv =====
// datapath of the warp unit: config registers, shared MAC, truncation,
// bounds check, source frame store and result register; depends on iapw_pkg
module iapw_dp #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iapw_pkg::t_dp_cmd                 i_cmd,
    input  logic [iapw_pkg::POS_W-1:0]        i_pos_x,
    input  logic [iapw_pkg::POS_W-1:0]        i_pos_y,
    input  logic [iapw_pkg::PIX_W-1:0]        i_pixel_in,
    input  logic                              i_cfg_we,
    input  logic [iapw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iapw_pkg::COEF_W-1:0]       i_cfg_data,
    output logic [iapw_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                              o_inside_res
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int ACC_W = iapw_pkg::ACC_W;
    localparam int SW    = ACC_W - FRAC_BITS;
    localparam logic [iapw_pkg::COEF_W-1:0] ONE_Q = iapw_pkg::COEF_W'(1) << FRAC_BITS;

    logic signed [iapw_pkg::COEF_W-1:0] r_coef_xx, r_coef_xy, r_offset_x;
    logic signed [iapw_pkg::COEF_W-1:0] r_coef_yx, r_coef_yy, r_offset_y;
    logic [iapw_pkg::DIM_W-1:0]         r_frame_w, r_frame_h;

    logic [iapw_pkg::POS_W-1:0]         r_px, r_py;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [SW-1:0]               r_sx, r_sy;
    logic [iapw_pkg::PIX_W-1:0]         r_rd_data;
    logic                               r_inside;
    logic [iapw_pkg::PIX_W-1:0]         r_mem [DEPTH];

    logic signed [iapw_pkg::COEF_W-1:0] w_mul_a;
    logic signed [iapw_pkg::POS_W:0]    w_mul_b;
    logic signed [iapw_pkg::PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]            w_addend;
    logic signed [ACC_W-1:0]            w_trunc_sum;
    logic signed [SW-1:0]               w_trunc;
    logic [AW-1:0]                      w_wr_addr;
    logic [AW-1:0]                      w_rd_addr;
    logic                               w_wr_in_store;
    logic                               w_x_in, w_y_in;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= ONE_Q;
            r_coef_xy  <= '0;
            r_offset_x <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= ONE_Q;
            r_offset_y <= '0;
            r_frame_w  <= iapw_pkg::DIM_W'(512);
            r_frame_h  <= iapw_pkg::DIM_W'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                iapw_pkg::REG_COEF_XX:  r_coef_xx  <= i_cfg_data;
                iapw_pkg::REG_COEF_XY:  r_coef_xy  <= i_cfg_data;
                iapw_pkg::REG_OFFSET_X: r_offset_x <= i_cfg_data;
                iapw_pkg::REG_COEF_YX:  r_coef_yx  <= i_cfg_data;
                iapw_pkg::REG_COEF_YY:  r_coef_yy  <= i_cfg_data;
                iapw_pkg::REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                iapw_pkg::REG_FRAME_W:  r_frame_w  <= i_cfg_data[iapw_pkg::DIM_W-1:0];
                iapw_pkg::REG_FRAME_H:  r_frame_h  <= i_cfg_data[iapw_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiply-accumulate
    always_comb begin
        unique case (i_cmd.mac_sel)
            iapw_pkg::MAC_XX: begin
                w_mul_a = r_coef_xx;
                w_mul_b = $signed({1'b0, r_px});
            end
            iapw_pkg::MAC_XY: begin
                w_mul_a = r_coef_xy;
                w_mul_b = $signed({1'b0, r_py});
            end
            iapw_pkg::MAC_YX: begin
                w_mul_a = r_coef_yx;
                w_mul_b = $signed({1'b0, r_px});
            end
            iapw_pkg::MAC_YY: begin
                w_mul_a = r_coef_yy;
                w_mul_b = $signed({1'b0, r_py});
            end
            default: begin
                w_mul_a = r_coef_xx;
                w_mul_b = $signed({1'b0, r_px});
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        if (!i_cmd.mac_init) begin
            w_addend = r_acc;
        end else if (i_cmd.mac_sel == iapw_pkg::MAC_XX) begin
            w_addend = ACC_W'(r_offset_x);
        end else begin
            w_addend = ACC_W'(r_offset_y);
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign w_trunc_sum = r_acc + (r_acc[ACC_W-1]
                         ? $signed({{SW{1'b0}}, {FRAC_BITS{1'b1}}})
                         : $signed(ACC_W'(0)));
    assign w_trunc     = w_trunc_sum[ACC_W-1:FRAC_BITS];

    // bounds against configured and maximum frame size
    assign w_x_in = !r_sx[SW-1]
                    && ($unsigned(r_sx) < SW'(r_frame_w))
                    && ($unsigned(r_sx) < SW'(MAX_WIDTH));
    assign w_y_in = !r_sy[SW-1]
                    && ($unsigned(r_sy) < SW'(r_frame_h))
                    && ($unsigned(r_sy) < SW'(MAX_HEIGHT));

    assign w_wr_in_store = (32'(i_pos_x) < MAX_WIDTH) && (32'(i_pos_y) < MAX_HEIGHT);
    assign w_wr_addr = AW'(AW'(i_pos_y) * AW'(MAX_WIDTH) + AW'(i_pos_x));
    assign w_rd_addr = AW'(AW'(r_sy[YW-1:0]) * AW'(MAX_WIDTH) + AW'(r_sx[XW-1:0]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
        if (i_cmd.mac_en) begin
            r_acc <= w_addend + ACC_W'(w_prod);
        end
        if (i_cmd.latch_sx) begin
            r_sx <= w_trunc;
        end
        if (i_cmd.latch_sy) begin
            r_sy <= w_trunc;
        end
        if (i_cmd.mem_rd) begin
            r_inside <= w_x_in && w_y_in;
        end
        if (i_cmd.out_load) begin
            o_pixel_out  <= r_inside ? r_rd_data : '0;
            o_inside_res <= r_inside;
        end
    end

    // source frame store: one write port for loads, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_wr_in_store) begin
            r_mem[w_wr_addr] <= i_pixel_in;
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

endmodule

// ===== tb/tb_inverse_affine_pixel_warp_unit.sv =====
// self-checking testbench of the inverse affine pixel warp unit
// drives load and warp requests against its own frame store and affine predictor
// depends on iapw_pkg and inverse_affine_pixel_warp_unit
module tb_inverse_affine_pixel_warp_unit;

    // clocking and run limits
    localparam int     CLK_PERIOD      = 12;
    localparam int     RESET_CYCLES    = 6;
    localparam int     WARP_LATENCY    = 7;
    localparam longint LIMIT_CYCLES    = 1_500_000;
    localparam int     DRAIN_LIMIT     = 20_000;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     RAND_PHASES     = 12;
    localparam int     ITEMS_PER_PHASE = 125;

    // geometry, must match the block's parameters
    localparam int MAX_W     = 512;
    localparam int MAX_H     = 512;
    localparam int FRAC      = 16;
    localparam int STORE_LEN = MAX_W * MAX_H;

    typedef struct packed {
        logic [iapw_pkg::PIX_W-1:0] pixel;
        logic                       in_frame;
    } t_warp_result;

    // rows of the directed stimulus
    typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_WARP} t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [iapw_pkg::CFG_IDX_W-1:0] idx;
        logic [iapw_pkg::COEF_W-1:0]    data;
        logic [iapw_pkg::POS_W-1:0]     x;
        logic [iapw_pkg::POS_W-1:0]     y;
        logic [iapw_pkg::PIX_W-1:0]     pix;
        logic                           typed;
        t_warp_result                   want;
    } t_dir_row;

    // which term of an affine row a random coefficient feeds
    typedef enum int {TERM_DIAG, TERM_CROSS, TERM_OFFSET} t_term;

    // first and last index past the register map
    localparam logic [iapw_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_LO = iapw_pkg::REG_FRAME_H + 4'd1;
    localparam logic [iapw_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_HI = 4'hF;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    logic                           i_command   = iapw_pkg::CMD_LOAD;
    logic [iapw_pkg::POS_W-1:0]     i_pos_x     = '0;
    logic [iapw_pkg::POS_W-1:0]     i_pos_y     = '0;
    logic [iapw_pkg::PIX_W-1:0]     i_pixel_in  = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [iapw_pkg::PIX_W-1:0]     o_pixel_out;
    logic                           o_inside_res;
    logic                           i_cfg_we    = 1'b0;
    logic [iapw_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [iapw_pkg::COEF_W-1:0]    i_cfg_data  = '0;

    // predictor state: register copies and the frame store image
    logic signed [iapw_pkg::COEF_W-1:0] cfg_coef [0:5];
    logic [iapw_pkg::DIM_W-1:0]         cfg_frame_w;
    logic [iapw_pkg::DIM_W-1:0]         cfg_frame_h;
    logic [iapw_pkg::PIX_W-1:0]         frame_model   [0:STORE_LEN-1];
    bit                                 frame_written [0:STORE_LEN-1];

    t_warp_result pending_warps [$];
    t_dir_row     directed_rows [$];
    int           mismatch_count = 0;
    bit           sender_steady  = 1'b0;
    bit           hold_request   = 1'b0;

    inverse_affine_pixel_warp_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // exact affine sum of one axis, truncated toward zero like a C int cast
    function automatic longint map_axis(logic signed [iapw_pkg::COEF_W-1:0] ca,
                                        logic signed [iapw_pkg::COEF_W-1:0] cb,
                                        logic signed [iapw_pkg::COEF_W-1:0] off,
                                        logic [iapw_pkg::POS_W-1:0] px,
                                        logic [iapw_pkg::POS_W-1:0] py);
        longint acc;
        longint mag;
        acc = longint'(ca) * longint'(px) + longint'(cb) * longint'(py) + longint'(off);
        if (acc < 0) begin
            mag = -acc;
            mag = mag >> FRAC;
            return -mag;
        end
        return acc >> FRAC;
    endfunction

    // maps a destination pixel to its source, returns 1 with the store index when inside
    function automatic bit locate_source(logic [iapw_pkg::POS_W-1:0] x,
                                         logic [iapw_pkg::POS_W-1:0] y,
                                         output int idx);
        longint sx;
        longint sy;
        longint fw;
        longint fh;
        // oversized frames clamp to the store size, zero leaves nothing inside
        fw = (cfg_frame_w > MAX_W) ? MAX_W : longint'(cfg_frame_w);
        fh = (cfg_frame_h > MAX_H) ? MAX_H : longint'(cfg_frame_h);
        sx = map_axis(cfg_coef[iapw_pkg::REG_COEF_XX], cfg_coef[iapw_pkg::REG_COEF_XY],
                      cfg_coef[iapw_pkg::REG_OFFSET_X], x, y);
        sy = map_axis(cfg_coef[iapw_pkg::REG_COEF_YX], cfg_coef[iapw_pkg::REG_COEF_YY],
                      cfg_coef[iapw_pkg::REG_OFFSET_Y], x, y);
        idx = 0;
        if (sx >= 0 && sx < fw && sy >= 0 && sy < fh) begin
            idx = int'(sy * MAX_W + sx);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_warp_result predict_warp(logic [iapw_pkg::POS_W-1:0] x,
                                                  logic [iapw_pkg::POS_W-1:0] y);
        t_warp_result res;
        int           idx;
        res = '0;
        if (locate_source(x, y, idx)) begin
            res.pixel    = frame_model[idx];
            res.in_frame = 1'b1;
        end
        return res;
    endfunction

    // short gaps mostly, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [iapw_pkg::POS_W-1:0] rand_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return '1;
        return iapw_pkg::POS_W'($urandom_range(0, MAX_W - 1));
    endfunction

    function automatic logic [iapw_pkg::PIX_W-1:0] rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return iapw_pkg::PIX_W'($urandom());
    endfunction

    // one coefficient for a given kind of transform
    function automatic logic [iapw_pkg::COEF_W-1:0] pick_coef(int kind, t_term term);
        int v;
        case (kind)
            0: begin
                // near identity with small shifts
                case (term)
                    TERM_DIAG:  v = 65536 + $urandom_range(0, 8191) - 4096;
                    TERM_CROSS: v = $urandom_range(0, 8191) - 4096;
                    default:    v = $urandom_range(0, 128 * 65536) - 64 * 65536;
                endcase
            end
            1: begin
                // scale, shear and rotation up to two in magnitude
                if (term == TERM_OFFSET) v = $urandom_range(0, 1 << 26) - (1 << 25);
                else v = $urandom_range(0, 262144) - 131072;
            end
            2: v = $urandom();
            3: begin
                // corner values of the coefficient range
                case ($urandom_range(0, 7))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 0;
                    3: v = 32'h0001_0000;
                    4: v = 32'hFFFF_0000;
                    5: v = 32'hFFFF_FFFF;
                    6: v = 1;
                    default: v = 32'hFFFF_8000;
                endcase
            end
            default: begin
                // pure scaling with an offset in [-1, 0), so small negatives truncate to 0
                case (term)
                    TERM_DIAG:  v = $urandom_range(0, 262144);
                    TERM_CROSS: v = 0;
                    default:    v = $urandom_range(0, 65535) - 65536;
                endcase
            end
        endcase
        return iapw_pkg::COEF_W'(v);
    endfunction

    // frame dimension write data, upper bits sometimes junk since only ten are kept
    function automatic logic [iapw_pkg::COEF_W-1:0] pick_frame_dim();
        logic [iapw_pkg::COEF_W-1:0] d;
        int                          r;
        d = '0;
        r = $urandom_range(0, 99);
        if (r < 60)      d[iapw_pkg::DIM_W-1:0] = iapw_pkg::DIM_W'($urandom_range(1, MAX_W));
        else if (r < 70) d[iapw_pkg::DIM_W-1:0] = iapw_pkg::DIM_W'(1);
        else if (r < 78) d[iapw_pkg::DIM_W-1:0] = iapw_pkg::DIM_W'(MAX_W);
        else if (r < 85) d[iapw_pkg::DIM_W-1:0] = '0;
        else if (r < 92) d[iapw_pkg::DIM_W-1:0] =
                             iapw_pkg::DIM_W'($urandom_range(MAX_W + 1, 1023));
        else             d[iapw_pkg::DIM_W-1:0] = iapw_pkg::DIM_W'($urandom_range(1, 64));
        if ($urandom_range(0, 3) == 0)
            d[iapw_pkg::COEF_W-1:iapw_pkg::DIM_W] =
                (iapw_pkg::COEF_W - iapw_pkg::DIM_W)'($urandom());
        return d;
    endfunction

    // builders of the directed rows
    function automatic void add_cfg(logic [iapw_pkg::CFG_IDX_W-1:0] idx,
                                    logic [iapw_pkg::COEF_W-1:0] data);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_load(logic [iapw_pkg::POS_W-1:0] x,
                                     logic [iapw_pkg::POS_W-1:0] y,
                                     logic [iapw_pkg::PIX_W-1:0] pix);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_LOAD;
        r.x    = x;
        r.y    = y;
        r.pix  = pix;
        directed_rows.push_back(r);
    endfunction

    // warp row, typed=1 carries a result read off directly
    function automatic void add_warp(logic [iapw_pkg::POS_W-1:0] x,
                                     logic [iapw_pkg::POS_W-1:0] y, logic typed,
                                     logic [iapw_pkg::PIX_W-1:0] pix, logic in_frame);
        t_dir_row r;
        r               = '0;
        r.kind          = ROW_WARP;
        r.x             = x;
        r.y             = y;
        r.typed         = typed;
        r.want.pixel    = pix;
        r.want.in_frame = in_frame;
        directed_rows.push_back(r);
    endfunction

    // offer one request, wait for acceptance, then update the predictor
    task automatic send_request(logic cmd, logic [iapw_pkg::POS_W-1:0] x,
                                logic [iapw_pkg::POS_W-1:0] y,
                                logic [iapw_pkg::PIX_W-1:0] pix, logic typed,
                                t_warp_result typed_res);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        // accepted at this edge
        if (cmd == iapw_pkg::CMD_LOAD) begin
            frame_model[int'(y) * MAX_W + int'(x)]   = pix;
            frame_written[int'(y) * MAX_W + int'(x)] = 1'b1;
        end else if (typed) begin
            pending_warps.push_back(typed_res);
        end else begin
            pending_warps.push_back(predict_warp(x, y));
        end
    endtask

    // a warp whose source would be a never-loaded entry gets that entry loaded first
    task automatic issue_warp(logic [iapw_pkg::POS_W-1:0] x, logic [iapw_pkg::POS_W-1:0] y,
                              logic typed, t_warp_result typed_res);
        int idx;
        if (locate_source(x, y, idx) && !frame_written[idx])
            send_request(iapw_pkg::CMD_LOAD, iapw_pkg::POS_W'(idx % MAX_W),
                         iapw_pkg::POS_W'(idx / MAX_W), rand_pixel(), 1'b0, '0);
        // pixel_in is junk on a warp and must be ignored
        send_request(iapw_pkg::CMD_WARP, x, y, iapw_pkg::PIX_W'($urandom()), typed, typed_res);
    endtask

    // drop valid, wait for all results and let the pipeline run dry
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_warps.size() != 0) @(posedge i_clk);
        repeat (WARP_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [iapw_pkg::CFG_IDX_W-1:0] idx,
                             logic [iapw_pkg::COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            iapw_pkg::REG_COEF_XX, iapw_pkg::REG_COEF_XY, iapw_pkg::REG_OFFSET_X,
            iapw_pkg::REG_COEF_YX, iapw_pkg::REG_COEF_YY, iapw_pkg::REG_OFFSET_Y:
                cfg_coef[idx] = data;
            iapw_pkg::REG_FRAME_W: cfg_frame_w = data[iapw_pkg::DIM_W-1:0];
            iapw_pkg::REG_FRAME_H: cfg_frame_h = data[iapw_pkg::DIM_W-1:0];
            default: ;  // unknown index, no effect
        endcase
    endtask

    // full register set for one random phase
    task automatic program_setting(int phase);
        int                             kind;
        logic [iapw_pkg::CFG_IDX_W-1:0] junk_idx;
        kind = phase % 5;
        write_reg(iapw_pkg::REG_COEF_XX, pick_coef(kind, TERM_DIAG));
        write_reg(iapw_pkg::REG_COEF_XY, pick_coef(kind, TERM_CROSS));
        write_reg(iapw_pkg::REG_OFFSET_X, pick_coef(kind, TERM_OFFSET));
        write_reg(iapw_pkg::REG_COEF_YX, pick_coef(kind, TERM_CROSS));
        write_reg(iapw_pkg::REG_COEF_YY, pick_coef(kind, TERM_DIAG));
        write_reg(iapw_pkg::REG_OFFSET_Y, pick_coef(kind, TERM_OFFSET));
        write_reg(iapw_pkg::REG_FRAME_W, pick_frame_dim());
        write_reg(iapw_pkg::REG_FRAME_H, pick_frame_dim());
        if ($urandom_range(0, 2) == 0) begin
            junk_idx = REG_UNKNOWN_LO + iapw_pkg::CFG_IDX_W'($urandom_range(0, 7));
            write_reg(junk_idx, iapw_pkg::COEF_W'($urandom()));
        end
    endtask

    // result sink: random stall runs, plus one long hold-off on request
    initial begin : result_sink
        int r;
        int run_left;
        bit stalling;
        run_left = 0;
        stalling = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long hold so the output register fills and the input backs up
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                run_left = 0;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        stalling = 1'b0;
                        run_left = $urandom_range(1, 8);
                    end else if (r < 55) begin
                        // stretch with no stall at all
                        stalling = 1'b0;
                        run_left = $urandom_range(30, 80);
                    end else if (r < 90) begin
                        stalling = 1'b1;
                        run_left = $urandom_range(1, 3);
                    end else begin
                        stalling = 1'b1;
                        run_left = $urandom_range(20, 60);
                    end
                end
                i_out_stall <= stalling;
                run_left--;
            end
        end
    end

    // compare every accepted result with the oldest pending one
    always @(posedge i_clk) begin : result_check
        t_warp_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_warps.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_pixel_out), '0);
            end else begin
                want = pending_warps.pop_front();
                if (o_pixel_out !== want.pixel)
                    report_mismatch("pixel_out", 32'(o_pixel_out), 32'(want.pixel));
                if (o_inside_res !== want.in_frame)
                    report_mismatch("inside_res", 32'(o_inside_res), 32'(want.in_frame));
            end
        end
    end

    initial begin : stimulus
        t_dir_row     row;
        t_warp_result typed_res;
        int           drain;

        // predictor at reset: identity transform, full frame, empty store
        cfg_coef[iapw_pkg::REG_COEF_XX]  = 32'h0001_0000;
        cfg_coef[iapw_pkg::REG_COEF_XY]  = '0;
        cfg_coef[iapw_pkg::REG_OFFSET_X] = '0;
        cfg_coef[iapw_pkg::REG_COEF_YX]  = '0;
        cfg_coef[iapw_pkg::REG_COEF_YY]  = 32'h0001_0000;
        cfg_coef[iapw_pkg::REG_OFFSET_Y] = '0;
        cfg_frame_w = iapw_pkg::DIM_W'(MAX_W);
        cfg_frame_h = iapw_pkg::DIM_W'(MAX_H);
        foreach (frame_written[i]) frame_written[i] = 1'b0;

        // store corners, then read them back through the reset transform
        add_load(9'd0, 9'd0, 24'hFF_FFFF);
        add_load(9'd511, 9'd511, 24'h00_0000);
        add_load(9'd511, 9'd0, 24'hA5_A5A5);
        add_load(9'd0, 9'd511, 24'h5A_5A5A);
        add_warp(9'd0, 9'd0, 1'b1, 24'hFF_FFFF, 1'b1);
        add_warp(9'd511, 9'd511, 1'b1, 24'h00_0000, 1'b1);
        add_warp(9'd511, 9'd0, 1'b1, 24'hA5_A5A5, 1'b1);
        add_warp(9'd0, 9'd511, 1'b1, 24'h5A_5A5A, 1'b1);
        // zero width, nothing is inside
        add_cfg(iapw_pkg::REG_FRAME_W, 32'd0);
        add_warp(9'd0, 9'd0, 1'b1, 24'h0, 1'b0);
        // width 1023 clamps to the store width
        add_cfg(iapw_pkg::REG_FRAME_W, 32'hFFFF_FFFF);
        add_warp(9'd511, 9'd0, 1'b1, 24'hA5_A5A5, 1'b1);
        // height one row
        add_cfg(iapw_pkg::REG_FRAME_H, 32'd1);
        add_warp(9'd0, 9'd511, 1'b1, 24'h0, 1'b0);
        add_warp(9'd511, 9'd0, 1'b1, 24'hA5_A5A5, 1'b1);
        // back to 512 with junk in the upper data bits
        add_cfg(iapw_pkg::REG_FRAME_H, 32'hFFFF_FE00);
        add_cfg(iapw_pkg::REG_FRAME_W, 32'd512);
        // minus one half truncates to zero, still inside
        add_cfg(iapw_pkg::REG_OFFSET_X, 32'hFFFF_8000);
        add_warp(9'd0, 9'd0, 1'b1, 24'hFF_FFFF, 1'b1);
        add_warp(9'd1, 9'd0, 1'b1, 24'hFF_FFFF, 1'b1);
        // minus one is outside
        add_cfg(iapw_pkg::REG_OFFSET_X, 32'hFFFF_0000);
        add_warp(9'd0, 9'd0, 1'b1, 24'h0, 1'b0);
        // huge sums fall outside without wrapping
        add_cfg(iapw_pkg::REG_OFFSET_X, 32'd0);
        add_cfg(iapw_pkg::REG_COEF_XX, 32'h7FFF_FFFF);
        add_warp(9'd511, 9'd0, 1'b1, 24'h0, 1'b0);
        add_cfg(iapw_pkg::REG_COEF_XX, 32'h8000_0000);
        add_warp(9'd1, 9'd0, 1'b1, 24'h0, 1'b0);
        // unknown indexes leave the map alone
        add_cfg(iapw_pkg::REG_COEF_XX, 32'h0001_0000);
        add_cfg(REG_UNKNOWN_LO, 32'hFFFF_FFFF);
        add_cfg(REG_UNKNOWN_HI, 32'h0000_0000);
        add_warp(9'd511, 9'd511, 1'b0, '0, 1'b0);
        // y path: constant row, then a mirror in x feeding y
        add_cfg(iapw_pkg::REG_COEF_YY, 32'd0);
        add_cfg(iapw_pkg::REG_OFFSET_Y, 32'h01FF_0000);
        add_warp(9'd0, 9'd0, 1'b0, '0, 1'b0);
        add_cfg(iapw_pkg::REG_COEF_YX, 32'hFFFF_0000);
        add_warp(9'd511, 9'd0, 1'b0, '0, 1'b0);
        // swap-like map through the cross terms
        add_cfg(iapw_pkg::REG_COEF_XX, 32'd0);
        add_cfg(iapw_pkg::REG_COEF_XY, 32'h0001_0000);
        add_warp(9'd3, 9'd7, 1'b0, '0, 1'b0);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed part
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_CFG: begin
                    settle_idle();
                    write_reg(row.idx, row.data);
                end
                ROW_LOAD: send_request(iapw_pkg::CMD_LOAD, row.x, row.y, row.pix, 1'b0, '0);
                default: begin
                    typed_res = row.want;
                    issue_warp(row.x, row.y, row.typed, typed_res);
                end
            endcase
        end

        // random phases, each under a fresh register setting
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            settle_idle();
            program_setting(phase);
            sender_steady = (phase % 4 == 3);
            if (phase == 2) hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 25)
                    send_request(iapw_pkg::CMD_LOAD, rand_pos(), rand_pos(), rand_pixel(),
                                 1'b0, '0);
                else
                    issue_warp(rand_pos(), rand_pos(), 1'b0, '0);
            end
        end

        // drain with a bound, then let the pipeline empty
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain = 0;
        while (pending_warps.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (WARP_LATENCY * 4) @(posedge i_clk);
        if (pending_warps.size() != 0)
            report_mismatch("results never arrived", 32'(pending_warps.size()), '0);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/iapw_pkg.sv
hdl/iapw_ctrl.sv
hdl/iapw_dp.sv
hdl/inverse_affine_pixel_warp_unit.sv
tb/tb_inverse_affine_pixel_warp_unit.sv
